/* rtl/ffh_pkg.sv */
// Shared constants, types and command codes of the first-fit heap allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package ffh_pkg;

    localparam int HEAP_BYTES   = 65536;
    localparam int HEADER_BYTES = 12;

    localparam int WORDS  = HEAP_BYTES / 4;
    localparam int WORD_W = $clog2(WORDS);
    localparam int STEP_W = $clog2(WORDS + 2);

    localparam int SIZE_W = 21;
    localparam int AW     = SIZE_W + 1;
    localparam int REQ_W  = 16;
    localparam int OFF_W  = 16;
    localparam int HDR_W  = 2 * SIZE_W + 1;

    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] prev;
        logic [SIZE_W-1:0] size;
    } t_hdr;

    typedef logic [2:0] t_asel;
    localparam t_asel ASEL_CUR = 3'd0;
    localparam t_asel ASEL_PRV = 3'd1;
    localparam t_asel ASEL_NXT = 3'd2;
    localparam t_asel ASEL_AFT = 3'd3;
    localparam t_asel ASEL_SPL = 3'd4;
    localparam t_asel ASEL_CLR = 3'd5;

    typedef logic [2:0] t_wsel;
    localparam t_wsel WSEL_CLR     = 3'd0;
    localparam t_wsel WSEL_SETFREE = 3'd1;
    localparam t_wsel WSEL_MRGP    = 3'd2;
    localparam t_wsel WSEL_PREVUPD = 3'd3;
    localparam t_wsel WSEL_MRGN    = 3'd4;
    localparam t_wsel WSEL_TAKE    = 3'd5;
    localparam t_wsel WSEL_SPLIT   = 3'd6;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic  ld_in;
        logic  mem_re;
        logic  mem_we;
        t_asel addr_sel;
        t_wsel wr_sel;
        logic  lat_c;
        logic  lat_p;
        logic  lat_n;
        logic  lat_m;
        logic  lat_t;
        logic  adv;
        logic  clr_inc;
        logic  resp;
        logic  fail;
    } t_cmd;

    typedef struct packed {
        logic bad_free;
        logic rd_free;
        logic prev_ok;
        logic fits;
        logic whole;
        logic sz_bad;
        logic nxt_in;
        logic aft_in;
        logic walk_ok;
        logic merged;
        logic nfree;
        logic clr_last;
    } t_sts;

endpackage

/* rtl/ffh_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module ffh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

/* rtl/ffh_dp.sv */
// Datapath of the heap allocator: header memory, walk and merge registers, result register.
// Depends on ffh_pkg and ffh_ram; driven by commands from ffh_ctrl.
module ffh_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ffh_pkg::t_cmd            i_cmd,
    input  logic                     i_operation,
    input  logic [ffh_pkg::REQ_W-1:0] i_request_bytes,
    input  logic [ffh_pkg::OFF_W-1:0] i_block_offset,
    output ffh_pkg::t_sts            o_sts,
    output logic                     o_done,
    output logic                     o_status,
    output logic [ffh_pkg::OFF_W-1:0] o_payload_offset
);
    import ffh_pkg::*;

    localparam logic [AW-1:0] HEAP_V = AW'(HEAP_BYTES);
    localparam logic [AW-1:0] HDR_V  = AW'(HEADER_BYTES);

    logic [AW-1:0]     r_cur, r_need, r_nxt, r_aft, r_prev;
    logic [SIZE_W-1:0] r_csz, r_nsz, r_fprev;
    logic              r_merged, r_nfree, r_op, r_bad;
    logic [STEP_W-1:0] r_steps;
    logic [WORD_W-1:0] r_clr;
    logic              r_done, r_status;
    logic [OFF_W-1:0]  r_poff;

    logic [HDR_W-1:0]  ram_q;
    t_hdr              rd, wdata;
    logic [AW-1:0]     byte_addr, pay, cur_f, need_in, rd_sz, rest;
    logic [WORD_W-1:0] addr;
    logic [SIZE_W-1:0] sum_p, sum_n;

    assign rd      = t_hdr'(ram_q);
    assign rd_sz   = AW'(rd.size);
    assign pay     = AW'(i_block_offset);
    assign cur_f   = pay - HDR_V;
    assign need_in = (AW'(i_request_bytes) + HDR_V + AW'(3)) & ~AW'(3);
    assign rest    = rd_sz - r_need;
    assign sum_p   = r_csz + rd.size;
    assign sum_n   = r_csz + r_nsz;

    always_comb begin
        unique case (i_cmd.addr_sel)
            ASEL_CUR: byte_addr = r_cur;
            ASEL_PRV: byte_addr = r_cur - r_prev;
            ASEL_NXT: byte_addr = r_nxt;
            ASEL_AFT: byte_addr = r_aft;
            ASEL_SPL: byte_addr = r_cur + r_need;
            default:  byte_addr = '0;
        endcase
        if (i_cmd.addr_sel == ASEL_CLR) begin
            addr = r_clr;
        end else begin
            addr = byte_addr[WORD_W+1:2];
        end
    end

    always_comb begin
        wdata = rd;
        unique case (i_cmd.wr_sel)
            WSEL_CLR: begin
                wdata = '0;
                if (r_clr == '0) begin
                    wdata.free = 1'b1;
                    wdata.size = SIZE_W'(HEAP_BYTES);
                end
            end
            WSEL_SETFREE: wdata.free = 1'b1;
            WSEL_MRGP:    wdata.size = sum_p;
            WSEL_PREVUPD: wdata.prev = r_csz;
            WSEL_MRGN: begin
                wdata.free = 1'b1;
                wdata.prev = r_fprev;
                wdata.size = sum_n;
            end
            WSEL_TAKE: begin
                wdata.free = 1'b0;
                wdata.size = o_sts.whole ? rd.size : r_need[SIZE_W-1:0];
            end
            WSEL_SPLIT: begin
                wdata.free = 1'b1;
                wdata.prev = r_need[SIZE_W-1:0];
                wdata.size = r_csz;
            end
            default: wdata = rd;
        endcase
    end

    ffh_ram #(
        .WIDTH (HDR_W),
        .DEPTH (WORDS)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_we),
        .i_waddr (addr),
        .i_wdata (HDR_W'(wdata)),
        .i_re    (i_cmd.mem_re),
        .i_raddr (addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.resp;
            if (i_cmd.clr_inc) begin
                r_clr <= r_clr + WORD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_op    <= i_operation;
            r_cur   <= (i_operation == OP_FREE) ? cur_f : '0;
            r_need  <= need_in;
            r_steps <= '0;
            r_bad   <= (pay < HDR_V) || (cur_f[1:0] != 2'b00) || (cur_f >= HEAP_V);
        end
        if (i_cmd.lat_c) begin
            r_nxt    <= r_cur + rd_sz;
            r_csz    <= rd.size;
            r_prev   <= AW'(rd.prev);
            r_fprev  <= rd.prev;
            r_merged <= 1'b0;
        end
        if (i_cmd.lat_p) begin
            r_csz    <= sum_p;
            r_cur    <= r_cur - r_prev;
            r_fprev  <= rd.prev;
            r_merged <= 1'b1;
        end
        if (i_cmd.lat_n) begin
            r_nsz   <= rd.size;
            r_nfree <= rd.free;
        end
        if (i_cmd.lat_m) begin
            r_csz <= sum_n;
            r_aft <= r_nxt + AW'(r_nsz);
        end
        if (i_cmd.lat_t) begin
            r_csz <= rest[SIZE_W-1:0];
            r_aft <= r_cur + rd_sz;
        end
        if (i_cmd.adv) begin
            r_cur   <= r_cur + rd_sz;
            r_steps <= r_steps + STEP_W'(1);
        end
        if (i_cmd.resp) begin
            r_status <= i_cmd.fail;
            if (i_cmd.fail || r_op == OP_FREE) begin
                r_poff <= '0;
            end else begin
                r_poff <= OFF_W'(r_cur + HDR_V);
            end
        end
    end

    always_comb begin
        o_sts.bad_free = r_bad;
        o_sts.rd_free  = rd.free;
        o_sts.prev_ok  = (rd.prev != '0) && (AW'(rd.prev) <= r_cur);
        o_sts.fits     = rd.free && (rd_sz >= r_need);
        o_sts.whole    = rest <= HDR_V;
        o_sts.sz_bad   = (rd.size == '0) || ((r_cur + rd_sz) > HEAP_V);
        o_sts.nxt_in   = r_nxt < HEAP_V;
        o_sts.aft_in   = r_aft < HEAP_V;
        o_sts.walk_ok  = (r_cur < HEAP_V) && (r_steps <= STEP_W'(WORDS));
        o_sts.merged   = r_merged;
        o_sts.nfree    = r_nfree;
        o_sts.clr_last = r_clr == WORD_W'(WORDS - 1);
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_payload_offset = r_poff;

endmodule

/* rtl/ffh_ctrl.sv */
// Controller state machine of the heap allocator: clear pass, allocate walk, free and merge.
// Depends on ffh_pkg; drives ffh_dp through the command struct.
module ffh_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          i_operation,
    input  ffh_pkg::t_sts i_sts,
    output ffh_pkg::t_cmd o_cmd,
    output logic          busy
);
    import ffh_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_FBEG = 4'd2;
    localparam logic [3:0] S_FC   = 4'd3;
    localparam logic [3:0] S_FRDP = 4'd4;
    localparam logic [3:0] S_FP   = 4'd5;
    localparam logic [3:0] S_FNXT = 4'd6;
    localparam logic [3:0] S_FN   = 4'd7;
    localparam logic [3:0] S_FN2  = 4'd8;
    localparam logic [3:0] S_AFT  = 4'd9;
    localparam logic [3:0] S_ACHK = 4'd10;
    localparam logic [3:0] S_AEV  = 4'd11;
    localparam logic [3:0] S_ASPL = 4'd12;
    localparam logic [3:0] S_AFTW = 4'd13;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                o_cmd.mem_we   = 1'b1;
                o_cmd.addr_sel = ASEL_CLR;
                o_cmd.wr_sel   = WSEL_CLR;
                o_cmd.clr_inc  = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.ld_in = 1'b1;
                    n_state     = (i_operation == OP_FREE) ? S_FBEG : S_ACHK;
                end
            end
            S_FBEG: begin
                if (i_sts.bad_free) begin
                    o_cmd.resp = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.mem_re   = 1'b1;
                    o_cmd.addr_sel = ASEL_CUR;
                    n_state        = S_FC;
                end
            end
            S_FC: begin
                o_cmd.mem_we   = 1'b1;
                o_cmd.addr_sel = ASEL_CUR;
                o_cmd.wr_sel   = WSEL_SETFREE;
                o_cmd.lat_c    = 1'b1;
                n_state        = i_sts.prev_ok ? S_FRDP : S_FNXT;
            end
            S_FRDP: begin
                o_cmd.mem_re   = 1'b1;
                o_cmd.addr_sel = ASEL_PRV;
                n_state        = S_FP;
            end
            S_FP: begin
                o_cmd.addr_sel = ASEL_PRV;
                o_cmd.wr_sel   = WSEL_MRGP;
                if (i_sts.rd_free) begin
                    o_cmd.mem_we = 1'b1;
                    o_cmd.lat_p  = 1'b1;
                end
                n_state = S_FNXT;
            end
            S_FNXT: begin
                if (i_sts.nxt_in) begin
                    o_cmd.mem_re   = 1'b1;
                    o_cmd.addr_sel = ASEL_NXT;
                    n_state        = S_FN;
                end else begin
                    o_cmd.resp = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_FN: begin
                o_cmd.lat_n    = 1'b1;
                o_cmd.addr_sel = ASEL_NXT;
                o_cmd.wr_sel   = WSEL_PREVUPD;
                o_cmd.mem_we   = i_sts.merged;
                n_state        = S_FN2;
            end
            S_FN2: begin
                if (i_sts.nfree) begin
                    o_cmd.mem_we   = 1'b1;
                    o_cmd.addr_sel = ASEL_CUR;
                    o_cmd.wr_sel   = WSEL_MRGN;
                    o_cmd.lat_m    = 1'b1;
                    n_state        = S_AFT;
                end else begin
                    o_cmd.resp = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_AFT: begin
                if (i_sts.aft_in) begin
                    o_cmd.mem_re   = 1'b1;
                    o_cmd.addr_sel = ASEL_AFT;
                    n_state        = S_AFTW;
                end else begin
                    o_cmd.resp = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_ACHK: begin
                if (i_sts.walk_ok) begin
                    o_cmd.mem_re   = 1'b1;
                    o_cmd.addr_sel = ASEL_CUR;
                    n_state        = S_AEV;
                end else begin
                    o_cmd.resp = 1'b1;
                    o_cmd.fail = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_AEV: begin
                priority if (i_sts.sz_bad) begin
                    o_cmd.resp = 1'b1;
                    o_cmd.fail = 1'b1;
                    n_state    = S_IDLE;
                end else if (i_sts.fits) begin
                    o_cmd.mem_we   = 1'b1;
                    o_cmd.addr_sel = ASEL_CUR;
                    o_cmd.wr_sel   = WSEL_TAKE;
                    o_cmd.lat_t    = 1'b1;
                    if (i_sts.whole) begin
                        o_cmd.resp = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_state = S_ASPL;
                    end
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = S_ACHK;
                end
            end
            S_ASPL: begin
                o_cmd.mem_we   = 1'b1;
                o_cmd.addr_sel = ASEL_SPL;
                o_cmd.wr_sel   = WSEL_SPLIT;
                n_state        = S_AFT;
            end
            S_AFTW: begin
                o_cmd.mem_we   = 1'b1;
                o_cmd.addr_sel = ASEL_AFT;
                o_cmd.wr_sel   = WSEL_PREVUPD;
                o_cmd.resp     = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = r_state != S_IDLE;

endmodule

/* rtl/first_fit_heap_allocator_top.sv */
// Top level of the first-fit boundary-tag heap allocator.
// Depends on ffh_pkg, ffh_ctrl, ffh_dp and ffh_ram.
//
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+-------------------------------------------
// command  | in        | start high, busy low   | i_operation, i_request_bytes, i_block_offset
// result   | out       | o_done for one cycle   | o_status, o_payload_offset
//
// After reset a clearing pass writes all 16384 header words, one per cycle, with busy high.
// An allocation reads and checks block headers from offset 0 until one fits, then may split it;
// a free marks the block free and merges it with a free previous block and a free next block.
// The result strobe comes in the cycle after the last step and busy is low in that cycle,
// so the next transfer can start at once. The receiver cannot stall the result.
module first_fit_heap_allocator_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_operation,
    input  logic [ffh_pkg::REQ_W-1:0] i_request_bytes,
    input  logic [ffh_pkg::OFF_W-1:0] i_block_offset,
    output logic                      o_done,
    output logic                      o_status,
    output logic [ffh_pkg::OFF_W-1:0] o_payload_offset
);
    import ffh_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ffh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .busy        (busy)
    );

    ffh_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_operation      (i_operation),
        .i_request_bytes  (i_request_bytes),
        .i_block_offset   (i_block_offset),
        .o_sts            (sts),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_payload_offset (o_payload_offset)
    );

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.mem_we && cmd.mem_re))
        else $error("Header memory read and write in the same cycle.");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted transfer did not make the block busy.");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("Result strobe held for more than one cycle.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_payload_offset == '0))
        else $error("Failed allocation returned a nonzero offset.");

endmodule

/* sim/tb_first_fit_heap_allocator_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench of first_fit_heap_allocator_top: allocate and free commands
// against a boundary-tag heap tracker held in a scoreboard class.
// Depends on ffh_pkg and the allocator RTL only.
module tb_first_fit_heap_allocator_top;

    localparam int unsigned HEAP   = ffh_pkg::HEAP_BYTES;
    localparam int unsigned HDR    = ffh_pkg::HEADER_BYTES;
    localparam int unsigned NWORDS = ffh_pkg::WORDS;
    localparam int          SW     = ffh_pkg::SIZE_W;
    localparam int          RW     = ffh_pkg::REQ_W;
    localparam int          OW     = ffh_pkg::OFF_W;

    localparam logic ST_DONE     = 1'b0;
    localparam logic ST_NO_SPACE = 1'b1;

    localparam int IDLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int BROKEN_ITEMS = 80;

    typedef struct packed {
        logic          status;
        logic [OW-1:0] offset;
    } t_reply;

    class heap_scoreboard;
        logic [SW-1:0] blk_len  [NWORDS];
        logic [SW-1:0] blk_back [NWORDS];
        bit            is_free  [NWORDS];
        t_reply        pending[$];
        int unsigned   live[$];
        int unsigned   released[$];
        int            errors;

        function new();
            for (int i = 0; i < NWORDS; i++) begin
                blk_len[i]  = '0;
                blk_back[i] = '0;
                is_free[i]  = 1'b0;
            end
            blk_len[0] = SW'(HEAP);
            is_free[0] = 1'b1;
            errors     = 0;
        endfunction

        function int unsigned slot(int unsigned off);
            return (off >> 2) % NWORDS;
        endfunction

        function bit carve_block(int unsigned req, output int unsigned payload);
            int unsigned need, cur, steps, cw, sz, split, rest, split_w;
            need    = (req + HDR + 3) & 32'hFFFF_FFFC;
            cur     = 0;
            steps   = 0;
            payload = 0;
            while (cur < HEAP && steps <= NWORDS) begin
                cw = slot(cur);
                sz = blk_len[cw];
                if (sz == 0 || sz > HEAP - cur) begin
                    return 1'b0;
                end
                if (is_free[cw] && sz >= need) begin
                    if (sz - need <= HDR) begin
                        need = sz;
                    end else begin
                        split            = cur + need;
                        rest             = sz - need;
                        split_w          = slot(split);
                        is_free[split_w] = 1'b1;
                        blk_back[split_w] = SW'(need);
                        blk_len[split_w]  = SW'(rest);
                        if (split + rest < HEAP) begin
                            blk_back[slot(split + rest)] = SW'(rest);
                        end
                    end
                    is_free[cw] = 1'b0;
                    blk_len[cw] = SW'(need);
                    payload     = cur + HDR;
                    return 1'b1;
                end
                cur += sz;
                steps++;
            end
            return 1'b0;
        endfunction

        function void release_block(int unsigned payload);
            int unsigned cur, cw, prv, pw, nxt, nw, after;
            if (payload >= HDR) begin
                cur = payload - HDR;
                if ((cur & 3) == 0 && cur < HEAP) begin
                    cw          = slot(cur);
                    nxt         = cur + blk_len[cw];
                    is_free[cw] = 1'b1;
                    if (blk_back[cw] != 0 && blk_back[cw] <= cur) begin
                        prv = cur - blk_back[cw];
                        pw  = slot(prv);
                        if (is_free[pw]) begin
                            blk_len[pw] = blk_len[pw] + blk_len[cw];
                            if (nxt < HEAP) begin
                                blk_back[slot(nxt)] = blk_len[pw];
                            end
                            cw = pw;
                        end
                    end
                    if (nxt < HEAP) begin
                        nw = slot(nxt);
                        if (is_free[nw]) begin
                            blk_len[cw] = blk_len[cw] + blk_len[nw];
                            after       = nxt + blk_len[nw];
                            if (after < HEAP) begin
                                blk_back[slot(after)] = blk_len[cw];
                            end
                        end
                    end
                end
            end
        endfunction

        function void note_command(logic op, logic [RW-1:0] req, logic [OW-1:0] off);
            t_reply      r;
            int unsigned p;
            int          idx;
            r        = '0;
            r.status = ST_DONE;
            if (op == ffh_pkg::OP_ALLOC) begin
                if (carve_block(req, p)) begin
                    r.offset = OW'(p);
                    live.push_back(p);
                end else begin
                    r.status = ST_NO_SPACE;
                end
            end else begin
                release_block(off);
                idx = -1;
                foreach (live[i]) begin
                    if (idx < 0 && live[i] == off) idx = i;
                end
                if (idx >= 0) begin
                    live.delete(idx);
                    released.push_back(off);
                    if (released.size() > 64) void'(released.pop_front());
                end
            end
            pending.push_back(r);
        endfunction

        function void check_reply(logic st, logic [OW-1:0] off);
            t_reply want;
            if (pending.size() == 0) begin
                $display("%0t: result with none expected: status %0d offset %0d",
                         $time, st, off);
                errors++;
            end else begin
                want = pending.pop_front();
                if (st !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, st);
                    errors++;
                end
                if (off !== want.offset) begin
                    $display("%0t: payload_offset expected %0d actual %0d",
                             $time, want.offset, off);
                    errors++;
                end
            end
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic          i_operation;
    logic [RW-1:0] i_request_bytes;
    logic [OW-1:0] i_block_offset;
    logic          o_done;
    logic          o_status;
    logic [OW-1:0] o_payload_offset;

    heap_scoreboard board;
    int             burst_left  = 0;
    int             idle_cycles = 0;

    first_fit_heap_allocator_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (i_operation),
        .i_request_bytes  (i_request_bytes),
        .i_block_offset   (i_block_offset),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_payload_offset (o_payload_offset)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            board.check_reply(o_status, o_payload_offset);
        end
    end

    always @(posedge i_clk) begin
        if ((i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic issue(logic op, logic [RW-1:0] req, logic [OW-1:0] off);
        start           <= 1'b1;
        i_operation     <= op;
        i_request_bytes <= req;
        i_block_offset  <= off;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_command(op, req, off);
    endtask

    task automatic paced(logic op, logic [RW-1:0] req, logic [OW-1:0] off);
        int gap;
        if (burst_left == 0) begin
            start <= 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        issue(op, req, off);
    endtask

    function automatic logic [RW-1:0] pick_request();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return RW'($urandom_range(0, 1023));
        if (r < 90) return RW'($urandom_range(0, 8191));
        if (r < 98) return RW'($urandom_range(0, 32767));
        return RW'($urandom);
    endfunction

    initial begin
        int          done_items;
        int unsigned kind;
        int unsigned thr;
        int unsigned off;
        int unsigned grant [4];

        board = new();
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_operation     <= ffh_pkg::OP_ALLOC;
        i_request_bytes <= '0;
        i_block_offset  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Whole-region cases: too large, exact fit, and remainders around the header size.
        paced(ffh_pkg::OP_ALLOC, 16'hFFFF, 16'h0000);
        paced(ffh_pkg::OP_ALLOC, RW'(HEAP - HDR), 16'hFFFF);
        paced(ffh_pkg::OP_ALLOC, '0, '0);
        paced(ffh_pkg::OP_FREE, 16'hFFFF, OW'(HDR));
        paced(ffh_pkg::OP_ALLOC, RW'(HEAP - HDR - 4), '0);
        paced(ffh_pkg::OP_FREE, '0, OW'(HDR));
        paced(ffh_pkg::OP_ALLOC, RW'(HEAP - 2 * HDR), '0);
        paced(ffh_pkg::OP_FREE, '0, OW'(HDR));
        paced(ffh_pkg::OP_ALLOC, RW'(HEAP - 2 * HDR - 4), '0);
        paced(ffh_pkg::OP_FREE, '0, OW'(HDR));

        // Small blocks, then frees that merge with no side, with the next block twice, and with both.
        paced(ffh_pkg::OP_ALLOC, 0, '0);
        paced(ffh_pkg::OP_ALLOC, 1, '0);
        paced(ffh_pkg::OP_ALLOC, 4, '0);
        paced(ffh_pkg::OP_ALLOC, 3, '0);
        for (int i = 0; i < 4; i++) grant[i] = board.live[i];
        paced(ffh_pkg::OP_FREE, '0, OW'(grant[1]));
        paced(ffh_pkg::OP_FREE, '0, OW'(grant[0]));
        paced(ffh_pkg::OP_FREE, '0, OW'(grant[3]));
        paced(ffh_pkg::OP_FREE, '0, OW'(grant[2]));

        // Offsets that must be ignored, and one that lands on a never-written header.
        paced(ffh_pkg::OP_FREE, '0, 16'h0000);
        paced(ffh_pkg::OP_FREE, '0, OW'(HDR - 1));
        paced(ffh_pkg::OP_FREE, '0, OW'(HDR + 1));
        paced(ffh_pkg::OP_FREE, '0, 16'hFFFF);
        paced(ffh_pkg::OP_FREE, '0, OW'(HEAP / 2));

        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                if (kind < 3) off = $urandom_range(0, HDR - 1);
                else off = ($urandom & 32'hFFFC) | $urandom_range(1, 3);
                paced(ffh_pkg::OP_FREE, RW'($urandom), OW'(off));
            end else begin
                if (board.live.size() > 48) thr = 85;
                else if (board.live.size() < 8) thr = 25;
                else thr = 55;
                if (board.live.size() != 0 && kind < thr) begin
                    paced(ffh_pkg::OP_FREE, RW'($urandom),
                          OW'(board.live[$urandom_range(0, board.live.size() - 1)]));
                end else begin
                    paced(ffh_pkg::OP_ALLOC, pick_request(), OW'($urandom));
                end
                done_items++;
            end
        end

        // Double frees, arbitrary aligned frees that corrupt the chain, live frees and allocations.
        for (int n = 0; n < BROKEN_ITEMS; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 30 && board.released.size() != 0) begin
                paced(ffh_pkg::OP_FREE, RW'($urandom),
                      OW'(board.released[$urandom_range(0, board.released.size() - 1)]));
            end else if (kind < 55) begin
                paced(ffh_pkg::OP_FREE, RW'($urandom),
                      OW'($urandom_range(HDR / 4, (HEAP - 4) / 4) * 4));
            end else if (kind < 75 && board.live.size() != 0) begin
                paced(ffh_pkg::OP_FREE, RW'($urandom),
                      OW'(board.live[$urandom_range(0, board.live.size() - 1)]));
            end else begin
                paced(ffh_pkg::OP_ALLOC, pick_request(), OW'($urandom));
            end
        end

        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/ffh_pkg.sv
rtl/ffh_ram.sv
rtl/ffh_dp.sv
rtl/ffh_ctrl.sv
rtl/first_fit_heap_allocator_top.sv
sim/tb_first_fit_heap_allocator_top.sv
